>>> rtl/tcfod_pkg.sv
package tcfod_pkg;

    localparam int MODE_W   = 2;
    localparam int STATUS_W = 2;
    localparam int PORT_STAMP_W = 32;
    localparam int WIDE_STAMP_W = 64;

    typedef enum logic [MODE_W-1:0] {
        MODE_ENQ     = 2'd0,
        MODE_DEQ_ANY = 2'd1,
        MODE_DEQ_A   = 2'd2,
        MODE_DEQ_B   = 2'd3
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    localparam logic CLASS_A = 1'b1;
    localparam logic CLASS_B = 1'b0;

    // Command into one class chain; push and pop never come together.
    typedef struct packed {
        logic push;
        logic pop;
    } t_fifo_ctl;

    typedef struct packed {
        logic empty;
        logic full;
    } t_fifo_sts;

endpackage

>>> rtl/tcfod_cell.sv
module tcfod_cell import tcfod_pkg::*; #(
    parameter int W = 32
) (
    input  logic         i_clk,
    input  logic         i_load,      // take the pushed stamp
    input  logic         i_shift,     // take the neighbor's stamp
    input  logic [W-1:0] i_push_data,
    input  logic [W-1:0] i_next_data,
    output logic [W-1:0] o_data
);

    logic [W-1:0] r_data;
    logic [W-1:0] n_data;

    always_comb begin
        n_data = r_data;
        if (i_load) begin
            n_data = i_push_data;
        end else if (i_shift) begin
            n_data = i_next_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

>>> rtl/tcfod_chain.sv
module tcfod_chain import tcfod_pkg::*; #(
    parameter int DEPTH = 16,
    parameter int W     = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_fifo_ctl    i_ctl,
    input  logic [W-1:0] i_push_data,
    output logic [W-1:0] o_head,
    output t_fifo_sts    o_sts
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [W-1:0]     w_q [DEPTH];

    // Head sits in cell 0; a pop moves every cell one step toward it.
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [W-1:0] w_next;
        if (g < DEPTH - 1) begin : g_mid
            assign w_next = w_q[g+1];
        end else begin : g_end
            assign w_next = '0;
        end
        tcfod_cell #(.W(W)) u_cell (
            .i_clk       (i_clk),
            .i_load      (i_ctl.push && (r_count == CNT_W'(g))),
            .i_shift     (i_ctl.pop),
            .i_push_data (i_push_data),
            .i_next_data (w_next),
            .o_data      (w_q[g])
        );
    end

    always_comb begin
        n_count = r_count;
        if (i_ctl.push) begin
            n_count = r_count + CNT_W'(1);
        end else if (i_ctl.pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    assign o_head      = w_q[0];
    assign o_sts.empty = (r_count == '0);
    assign o_sts.full  = (r_count == CNT_W'(DEPTH));

endmodule

>>> rtl/two_class_fifo_oldest_dequeue_unit.sv
// Two class FIFOs of arrival stamps (class A and class B), each a chain of
// QUEUE_DEPTH shift cells whose head always sits in the first cell. Every input
// beat yields exactly one output beat: an enqueue reports ok or full, a dequeue
// reports ok with the class and stamp, or empty. Dequeue-any takes the head with
// the smaller stamp, class B on a tie, and the non-empty class when one is empty.
// The head compare and the push or pop of the chosen chain happen in the
// accepting cycle, and the result lands in the output register, so the block
// takes one beat per cycle as long as the output side drains. Stamps are held
// to their low STAMP_BITS bits and compared unsigned.
module two_class_fifo_oldest_dequeue_unit import tcfod_pkg::*; #(
    parameter int QUEUE_DEPTH = 16,
    parameter int STAMP_BITS  = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_s_tvalid,
    output logic                    o_s_tready,
    input  logic [PORT_STAMP_W-1:0] i_s_tdata,  // [31:0] arrival_stamp
    input  logic [2:0]              i_s_tuser,  // [1:0] mode, [2] item_class
    output logic                    o_m_tvalid,
    input  logic                    i_m_tready,
    output logic [PORT_STAMP_W-1:0] o_m_tdata,  // [31:0] out_stamp
    output logic [2:0]              o_m_tuser   // [1:0] status, [2] out_class
);

    logic                  w_accept;
    t_mode                 w_mode;
    logic                  w_class;
    logic [WIDE_STAMP_W-1:0] w_in_wide;
    logic [STAMP_BITS-1:0] w_in_stamp;

    t_fifo_ctl             w_ctl_a;
    t_fifo_ctl             w_ctl_b;
    t_fifo_sts             w_sts_a;
    t_fifo_sts             w_sts_b;
    logic [STAMP_BITS-1:0] w_head_a;
    logic [STAMP_BITS-1:0] w_head_b;

    t_status               w_status;
    logic                  w_out_class;
    logic [STAMP_BITS-1:0] w_out_stamp;
    logic [WIDE_STAMP_W-1:0] w_out_wide;

    logic                    r_valid;
    logic                    n_valid;
    t_status                 r_status;
    logic                    r_class;
    logic [PORT_STAMP_W-1:0] r_stamp;

    assign o_s_tready = !r_valid || i_m_tready;
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_mode     = t_mode'(i_s_tuser[1:0]);
    assign w_class    = i_s_tuser[2];
    assign w_in_wide  = WIDE_STAMP_W'(i_s_tdata);
    assign w_in_stamp = w_in_wide[STAMP_BITS-1:0];

    tcfod_chain #(.DEPTH(QUEUE_DEPTH), .W(STAMP_BITS)) u_chain_a (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_ctl_a),
        .i_push_data (w_in_stamp),
        .o_head      (w_head_a),
        .o_sts       (w_sts_a)
    );

    tcfod_chain #(.DEPTH(QUEUE_DEPTH), .W(STAMP_BITS)) u_chain_b (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_ctl_b),
        .i_push_data (w_in_stamp),
        .o_head      (w_head_b),
        .o_sts       (w_sts_b)
    );

    // Pick the operation and the source chain for the accepted beat.
    always_comb begin
        w_ctl_a     = '0;
        w_ctl_b     = '0;
        w_status    = ST_OK;
        w_out_class = CLASS_B;
        w_out_stamp = '0;
        case (w_mode)
            MODE_ENQ: begin
                if (w_class == CLASS_A) begin
                    if (w_sts_a.full) w_status = ST_FULL;
                    else              w_ctl_a.push = w_accept;
                end else begin
                    if (w_sts_b.full) w_status = ST_FULL;
                    else              w_ctl_b.push = w_accept;
                end
            end
            MODE_DEQ_ANY: begin
                if (w_sts_a.empty && w_sts_b.empty) begin
                    w_status = ST_EMPTY;
                end else if (!w_sts_a.empty && (w_sts_b.empty || (w_head_a < w_head_b))) begin
                    w_ctl_a.pop = w_accept;
                    w_out_class = CLASS_A;
                    w_out_stamp = w_head_a;
                end else begin
                    w_ctl_b.pop = w_accept;
                    w_out_stamp = w_head_b;
                end
            end
            MODE_DEQ_A: begin
                if (w_sts_a.empty) begin
                    w_status = ST_EMPTY;
                end else begin
                    w_ctl_a.pop = w_accept;
                    w_out_class = CLASS_A;
                    w_out_stamp = w_head_a;
                end
            end
            MODE_DEQ_B: begin
                if (w_sts_b.empty) begin
                    w_status = ST_EMPTY;
                end else begin
                    w_ctl_b.pop = w_accept;
                    w_out_stamp = w_head_b;
                end
            end
            default: begin
                w_status = ST_OK;
            end
        endcase
    end

    assign w_out_wide = WIDE_STAMP_W'(w_out_stamp);

    always_comb begin
        n_valid = r_valid;
        if (w_accept) begin
            n_valid = 1'b1;
        end else if (i_m_tready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Hold the result beat until the sink takes it.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status <= w_status;
            r_class  <= w_out_class;
            r_stamp  <= w_out_wide[PORT_STAMP_W-1:0];
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = r_stamp;
    assign o_m_tuser  = {r_class, r_status};

endmodule

>>> verif/tcfod_checker.sv
module tcfod_checker import tcfod_pkg::*; #(
    parameter int QUEUE_DEPTH = 16,
    parameter int STAMP_BITS  = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_s_tvalid,
    input  logic                    i_s_tready,
    input  logic [PORT_STAMP_W-1:0] i_s_tdata,  // [31:0] arrival_stamp
    input  logic [2:0]              i_s_tuser,  // [1:0] mode, [2] item_class
    input  logic                    i_m_tvalid,
    input  logic                    i_m_tready,
    input  logic [PORT_STAMP_W-1:0] i_m_tdata,  // [31:0] out_stamp
    input  logic [2:0]              i_m_tuser,  // [1:0] status, [2] out_class
    output int                      o_fail_count,
    output int                      o_due_count,
    output int                      o_served_count,
    output int                      o_full_count,
    output int                      o_empty_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        t_status                 status;
        logic                    out_class;
        logic [PORT_STAMP_W-1:0] stamp;
    } t_reply;

    localparam logic [WIDE_STAMP_W-1:0] KEEP_MASK =
        (STAMP_BITS >= WIDE_STAMP_W) ? '1 : ((64'd1 << STAMP_BITS) - 64'd1);

    logic [PORT_STAMP_W-1:0] line_a[$];
    logic [PORT_STAMP_W-1:0] line_b[$];
    t_reply                  due_replies[$];

    int fails   = 0;
    int served  = 0;
    int fulls   = 0;
    int empties = 0;

    // Apply one request to the two stamp lines and return the reply it earns.
    function automatic t_reply serve_request(t_mode mode, logic cls,
                                             logic [PORT_STAMP_W-1:0] stamp);
        t_reply reply;
        logic   have;
        logic   take_a;
        reply  = '{status: ST_OK, out_class: CLASS_B, stamp: '0};
        have   = 1'b0;
        take_a = 1'b0;
        case (mode)
            MODE_ENQ: begin
                if (cls == CLASS_A) begin
                    if (line_a.size() < QUEUE_DEPTH)
                        line_a.push_back(stamp & KEEP_MASK[PORT_STAMP_W-1:0]);
                    else
                        reply.status = ST_FULL;
                end else begin
                    if (line_b.size() < QUEUE_DEPTH)
                        line_b.push_back(stamp & KEEP_MASK[PORT_STAMP_W-1:0]);
                    else
                        reply.status = ST_FULL;
                end
            end
            MODE_DEQ_ANY: begin
                have = (line_a.size() != 0) || (line_b.size() != 0);
                // tie goes to class B
                take_a = (line_b.size() == 0) ||
                         (line_a.size() != 0 && line_a[0] < line_b[0]);
            end
            MODE_DEQ_A: begin
                have   = line_a.size() != 0;
                take_a = 1'b1;
            end
            default: begin
                have   = line_b.size() != 0;
                take_a = 1'b0;
            end
        endcase
        if (mode != MODE_ENQ) begin
            if (!have) begin
                reply.status = ST_EMPTY;
            end else if (take_a) begin
                reply.out_class = CLASS_A;
                reply.stamp     = line_a.pop_front();
            end else begin
                reply.out_class = CLASS_B;
                reply.stamp     = line_b.pop_front();
            end
        end
        return reply;
    endfunction

    always @(posedge i_clk) begin
        t_reply want;
        t_reply got;
        if (!i_rst_n) begin
            line_a.delete();
            line_b.delete();
            due_replies.delete();
        end else begin
            // predict first so a same-edge result still meets the oldest entry
            if (i_s_tvalid && i_s_tready) begin
                want = serve_request(t_mode'(i_s_tuser[1:0]), i_s_tuser[2], i_s_tdata);
                due_replies.push_back(want);
                if (want.status == ST_FULL)
                    fulls++;
                else if (want.status == ST_EMPTY)
                    empties++;
                else if (t_mode'(i_s_tuser[1:0]) != MODE_ENQ)
                    served++;
            end
            if (i_m_tvalid && i_m_tready) begin
                got = '{status: t_status'(i_m_tuser[1:0]), out_class: i_m_tuser[2],
                        stamp: i_m_tdata};
                if (due_replies.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("[%0t] result beat with nothing pending: ",
                                 "status %0d class %0d stamp %h",
                                 $time, got.status, got.out_class, got.stamp);
                end else begin
                    want = due_replies.pop_front();
                    if (got.status !== want.status || got.out_class !== want.out_class ||
                        got.stamp !== want.stamp) begin
                        fails++;
                        if (fails <= 10)
                            $display("[%0t] mismatch: expected status %0d class %0d ",
                                     "stamp %h, got status %0d class %0d stamp %h",
                                     $time, want.status, want.out_class, want.stamp,
                                     got.status, got.out_class, got.stamp);
                    end
                end
            end
        end
        o_fail_count   <= fails;
        o_due_count    <= due_replies.size();
        o_served_count <= served;
        o_full_count   <= fulls;
        o_empty_count  <= empties;
    end

endmodule

>>> verif/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tcfod_pkg::*;

    localparam int QUEUE_DEPTH  = 16;
    localparam int STAMP_BITS   = 32;
    localparam int RANDOM_BEATS = 900;
    localparam int MAX_GAP      = 13;
    localparam int CYCLE_LIMIT  = 300000;

    logic                    i_clk    = 1'b0;
    logic                    i_rst_n  = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [PORT_STAMP_W-1:0] s_tdata  = '0;  // [31:0] arrival_stamp
    logic [2:0]              s_tuser  = '0;  // [1:0] mode, [2] item_class
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [PORT_STAMP_W-1:0] m_tdata;        // [31:0] out_stamp
    logic [2:0]              m_tuser;        // [1:0] status, [2] out_class

    int fail_count;
    int due_count;
    int served_count;
    int full_count;
    int empty_count;

    int                      cycle_count   = 0;
    int                      beats_sent    = 0;
    int                      mode_tally[4] = '{default: 0};
    logic                    quiet         = 1'b0;
    logic [PORT_STAMP_W-1:0] stamp_clock   = '0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    two_class_fifo_oldest_dequeue_unit #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .STAMP_BITS  (STAMP_BITS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser)
    );

    tcfod_checker #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .STAMP_BITS  (STAMP_BITS)
    ) u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_tvalid     (s_tvalid),
        .i_s_tready     (s_tready),
        .i_s_tdata      (s_tdata),
        .i_s_tuser      (s_tuser),
        .i_m_tvalid     (m_tvalid),
        .i_m_tready     (m_tready),
        .i_m_tdata      (m_tdata),
        .i_m_tuser      (m_tuser),
        .o_fail_count   (fail_count),
        .o_due_count    (due_count),
        .o_served_count (served_count),
        .o_full_count   (full_count),
        .o_empty_count  (empty_count)
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Mostly rising stamps as real arrivals give, some repeats, some arbitrary.
    function automatic logic [PORT_STAMP_W-1:0] fresh_stamp();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 14) begin
            stamp_clock += $urandom_range(0, 3);
            return stamp_clock;
        end
        if (pick < 17)
            return $urandom;
        return $urandom_range(0, 3);
    endfunction

    // Called at the edge that accepted the previous beat; keep tvalid high on a zero gap.
    task automatic send_beat(t_mode mode, logic cls, logic [PORT_STAMP_W-1:0] stamp);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= {cls, mode};
        s_tdata  <= stamp;
        do @(posedge i_clk); while (!s_tready);
        mode_tally[mode]++;
        beats_sent++;
    endtask

    task automatic enqueue(logic cls, logic [PORT_STAMP_W-1:0] stamp);
        send_beat(MODE_ENQ, cls, stamp);
    endtask

    // Class and data bits are don't-care on a dequeue: fill them with noise.
    task automatic dequeue(t_mode mode);
        send_beat(mode, 1'($urandom), $urandom);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge i_clk); while (due_count != 0);
    endtask

    initial begin
        int   stall;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            stall = quiet ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_tready <= 1'b1;
            do @(posedge i_clk); while (!m_tvalid);
        end
    end

    initial begin
        logic  cls;
        t_mode mode;
        int    roll;
        int    directed;
        logic  paused;
        paused = 1'b0;
        stamp_clock = $urandom_range(0, 255);
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty pops on every dequeue flavor
        dequeue(MODE_DEQ_ANY);
        dequeue(MODE_DEQ_A);
        dequeue(MODE_DEQ_B);
        // equal heads at the top stamp: class B first
        enqueue(CLASS_A, '1);
        enqueue(CLASS_B, '1);
        dequeue(MODE_DEQ_ANY);
        dequeue(MODE_DEQ_ANY);
        // one side empty
        enqueue(CLASS_A, 32'd5);
        dequeue(MODE_DEQ_ANY);
        enqueue(CLASS_B, 32'd0);
        dequeue(MODE_DEQ_ANY);
        // unsigned compare across the top bit
        enqueue(CLASS_A, 32'h7fff_ffff);
        enqueue(CLASS_B, 32'h8000_0000);
        enqueue(CLASS_A, 32'h0000_0001);
        dequeue(MODE_DEQ_ANY);
        dequeue(MODE_DEQ_B);
        dequeue(MODE_DEQ_A);
        dequeue(MODE_DEQ_A);
        dequeue(MODE_DEQ_B);
        wait_drained();
        directed = beats_sent;

        while (beats_sent < directed + RANDOM_BEATS) begin
            quiet = ($urandom_range(0, 4) == 0);
            case ($urandom_range(0, 9))
                0, 1: begin
                    // push one class hard, usually past full
                    cls = 1'($urandom);
                    repeat ($urandom_range(14, 20)) enqueue(cls, fresh_stamp());
                end
                2, 3: begin
                    mode = t_mode'(MODE_W'($urandom_range(1, 3)));
                    repeat ($urandom_range(14, 20)) dequeue(mode);
                end
                default: begin
                    repeat ($urandom_range(10, 30)) begin
                        roll = $urandom_range(0, 99);
                        if (roll < 50)
                            enqueue(1'($urandom), fresh_stamp());
                        else if (roll < 75)
                            dequeue(MODE_DEQ_ANY);
                        else if (roll < 88)
                            dequeue(MODE_DEQ_A);
                        else
                            dequeue(MODE_DEQ_B);
                    end
                end
            endcase
            if (!paused && beats_sent > directed + RANDOM_BEATS / 2) begin
                wait_drained();
                paused = 1'b1;
            end
        end

        wait_drained();
        repeat (4) @(posedge i_clk);

        $display("Drove %0d beats: %0d enqueue, %0d dequeue-any, %0d dequeue-A, %0d dequeue-B.",
                 beats_sent, mode_tally[MODE_ENQ], mode_tally[MODE_DEQ_ANY],
                 mode_tally[MODE_DEQ_A], mode_tally[MODE_DEQ_B]);
        $display("Checked in order: %0d stamps popped, %0d refused on full, %0d empty pops.",
                 served_count, full_count, empty_count);
        if (fail_count == 0 && due_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
